/* rtl/core/xhfr_pkg.sv */
`timescale 1ns / 1ps

package xhfr_pkg;

    localparam int HDR_LEN   = 5;
    localparam int FILL_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef logic [7:0]                byte_t;
    typedef logic [15:0]               len_t;
    typedef logic [FILL_W-1:0]         fill_t;
    typedef logic [HDR_LEN-1:0][7:0]   window_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0]      cfg_dat_t;

    localparam byte_t    SYNC_RESET        = 8'h78;
    localparam len_t     MAX_PAYLOAD_RESET = 16'hFFFF;
    localparam fill_t    FILL_FULL         = fill_t'(HDR_LEN);
    localparam cfg_idx_t CFG_SYNC_BYTE     = 2'd0;
    localparam cfg_idx_t CFG_MAX_PAYLOAD   = 2'd1;

    // window after the new byte and the outcome of the header test
    typedef struct packed {
        window_t window;
        fill_t   fill;
        logic    accept;
        len_t    len;
    } hdr_t;

    typedef struct packed {
        byte_t payload_byte;
        logic  is_last;
        logic  empty_frame;
    } result_t;

endpackage

/* rtl/core/xhfr_if.sv */
`timescale 1ns / 1ps

interface xhfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xhfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       is_last;
    logic       empty_frame;

    modport source (output valid, output payload_byte, output is_last,
                    output empty_frame, input ready);
    modport sink   (input valid, input payload_byte, input is_last,
                    input empty_frame, output ready);
endinterface

interface xhfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/xhfr_hdr_check.sv */
`timescale 1ns / 1ps

module xhfr_hdr_check
    import xhfr_pkg::*;
(
    input  window_t window,
    input  fill_t   fill,
    input  byte_t   rx_byte,
    input  byte_t   sync_byte,
    input  len_t    max_payload,
    output hdr_t    hdr
);

    window_t nw;
    fill_t   nfill;
    byte_t   x;
    len_t    len;
    logic    full;

    always_comb
    begin
        nw    = window;
        nfill = fill;
        if (fill < FILL_FULL)
        begin
            nw[fill] = rx_byte;
            nfill    = fill + fill_t'(1);
        end
        else
        begin
            // slide by one byte, newest at the top
            for (int i = 0; i < HDR_LEN - 1; i++)
            begin
                nw[i] = window[i+1];
            end
            nw[HDR_LEN-1] = rx_byte;
        end

        x = '0;
        for (int i = 0; i < HDR_LEN; i++)
        begin
            x = x ^ nw[i];
        end

        full = (nfill == FILL_FULL);
        len  = {nw[3], nw[2]};

        hdr.window = nw;
        hdr.fill   = nfill;
        hdr.len    = len;
        hdr.accept = full && (nw[0] == sync_byte) && (x == '0) && (len <= max_payload);
    end

endmodule

/* rtl/core/xhfr_frame_ctrl.sv */
`timescale 1ns / 1ps

module xhfr_frame_ctrl
    import xhfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  byte_t   rx_byte,
    input  byte_t   sync_byte,
    input  len_t    max_payload,
    output logic    res_valid,
    output result_t res
);

    window_t window_reg, window_next;
    fill_t   fill_reg, fill_next;
    logic    in_payload_reg, in_payload_next;
    len_t    bytes_left_reg, bytes_left_next;
    hdr_t    hdr;

    xhfr_hdr_check u_hdr_check (
        .window      (window_reg),
        .fill        (fill_reg),
        .rx_byte     (rx_byte),
        .sync_byte   (sync_byte),
        .max_payload (max_payload),
        .hdr         (hdr)
    );

    always_comb
    begin
        window_next     = window_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (in_payload_reg)
        begin
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
            res.is_last      = (bytes_left_reg <= len_t'(1));
            if (res.is_last)
            begin
                bytes_left_next = '0;
                in_payload_next = 1'b0;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - len_t'(1);
            end
        end
        else if (hdr.accept)
        begin
            window_next = '0;
            fill_next   = '0;
            if (hdr.len == '0)
            begin
                res_valid       = 1'b1;
                res.is_last     = 1'b1;
                res.empty_frame = 1'b1;
            end
            else
            begin
                bytes_left_next = hdr.len;
                in_payload_next = 1'b1;
            end
        end
        else
        begin
            window_next = hdr.window;
            fill_next   = hdr.fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else if (step)
        begin
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

/* rtl/core/xor_header_frame_receiver_top.sv */
`timescale 1ns / 1ps

// channel  direction  handshake      payload
// rx       in         valid/ready    rx_byte[7:0]
// cfg      in         valid/ready    index[1:0], data[15:0]
// res      out        valid/ready    payload_byte[7:0], is_last, empty_frame
//
// one byte per cycle sustained while res is ready; a result is written to the
// output register once its byte has passed the input register and the frame logic
// the five-byte xor and compare sit in the single stage between the registers
// reset clears the window, frame state and registers to sync 0x78, max 65535
// a stalled output holds its result; the input register still takes one more
// byte, then rx ready drops until the result is taken

module xor_header_frame_receiver_top
    import xhfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    xhfr_rx_if.sink       rx,
    xhfr_cfg_if.sink      cfg,
    xhfr_res_if.source    res
);

    byte_t   sync_byte_reg;
    len_t    max_payload_reg;
    logic    s1_valid_reg;
    byte_t   s1_byte_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    advance;
    logic    ctrl_valid;
    result_t ctrl_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= SYNC_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SYNC_BYTE:   sync_byte_reg   <= cfg.data[7:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // stage 1 moves on when the output register is free or being emptied
    assign advance  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    xhfr_frame_ctrl u_frame_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (s1_byte_reg),
        .sync_byte   (sync_byte_reg),
        .max_payload (max_payload_reg),
        .res_valid   (ctrl_valid),
        .res         (ctrl_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = ctrl_valid;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl_valid)
        begin
            out_reg <= ctrl_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.payload_byte = out_reg.payload_byte;
    assign res.is_last      = out_reg.is_last;
    assign res.empty_frame  = out_reg.empty_frame;

    a_empty_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.empty_frame |-> res.is_last && (res.payload_byte == '0))
        else $error("empty frame result without is_last or with nonzero byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |-> !advance)
        else $error("stalled result overwritten by stage 1");

    a_rx_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready |=> s1_valid_reg)
        else $error("accepted byte lost before stage 1");

    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("stage 1 byte changed while stalled");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import xhfr_pkg::*;

    localparam int       CLK_PERIOD  = 12;
    localparam int       CYCLE_LIMIT = 400000;
    localparam int       IDLE_PCT    = 11;
    localparam int       HOLD_CYCLES = 160;
    localparam int       PHASE_BYTES = 112;
    localparam int       NUM_PHASES  = 8;
    localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

    logic clk;
    logic rst_n;

    xhfr_rx_if  rx_ch ();
    xhfr_cfg_if cfg_ch ();
    xhfr_res_if res_ch ();

    xor_header_frame_receiver_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    byte_t   rx_stream_q[$];
    result_t deframed_q[$];

    // shadow of the deframer state and its registers
    byte_t   hunt_win[HDR_LEN];
    int      hunt_fill;
    logic    streaming;
    len_t    bytes_left;
    byte_t   sync_reg;
    len_t    max_len_reg;

    int      rx_accepted;
    int      results_seen;
    int      frames_closed;
    int      empty_seen;
    int      cfg_writes;
    int      mismatch_count;
    int      cycle_count;
    logic    sink_hold = 1'b0;
    logic    hold_req  = 1'b0;
    logic    no_idle;
    result_t want;

    // full-rate stretch on both sides
    assign no_idle = (rx_accepted >= 450) && (rx_accepted < 620);

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic deframe_byte(input byte_t b);
        byte_t   x;
        len_t    len;
        result_t r;
        int      i;
        if (streaming)
        begin
            r.payload_byte = b;
            r.is_last      = (bytes_left <= 16'd1);
            r.empty_frame  = 1'b0;
            deframed_q.push_back(r);
            if (r.is_last)
            begin
                streaming  = 1'b0;
                bytes_left = '0;
            end
            else
                bytes_left = bytes_left - 16'd1;
        end
        else
        begin
            if (hunt_fill < HDR_LEN)
            begin
                hunt_win[hunt_fill] = b;
                hunt_fill++;
            end
            else
            begin
                for (i = 0; i < HDR_LEN - 1; i++)
                    hunt_win[i] = hunt_win[i + 1];
                hunt_win[HDR_LEN - 1] = b;
            end
            if (hunt_fill == HDR_LEN)
            begin
                x = '0;
                for (i = 0; i < HDR_LEN; i++)
                    x = x ^ hunt_win[i];
                len = {hunt_win[3], hunt_win[2]};
                if (hunt_win[0] == sync_reg && x == 8'h00 && len <= max_len_reg)
                begin
                    foreach (hunt_win[j])
                        hunt_win[j] = '0;
                    hunt_fill = 0;
                    if (len == 16'd0)
                    begin
                        r.payload_byte = '0;
                        r.is_last      = 1'b1;
                        r.empty_frame  = 1'b1;
                        deframed_q.push_back(r);
                    end
                    else
                    begin
                        streaming  = 1'b1;
                        bytes_left = len;
                    end
                end
            end
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_byte(rx_ch.rx_byte);
                rx_accepted <= rx_accepted + 1;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (rx_stream_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_stream_q.pop_front();
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (deframed_q.size() == 0)
                    report_mismatch($sformatf("unexpected transaction byte %02h last %0b empty %0b",
                                              res_ch.payload_byte, res_ch.is_last,
                                              res_ch.empty_frame));
                else
                begin
                    want = deframed_q.pop_front();
                    if (res_ch.payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                                  res_ch.payload_byte, want.payload_byte));
                    if (res_ch.is_last !== want.is_last)
                        report_mismatch($sformatf("is_last %0b, expected %0b",
                                                  res_ch.is_last, want.is_last));
                    if (res_ch.empty_frame !== want.empty_frame)
                        report_mismatch($sformatf("empty_frame %0b, expected %0b",
                                                  res_ch.empty_frame, want.empty_frame));
                    if (want.is_last)
                        frames_closed++;
                    if (want.empty_frame)
                        empty_seen++;
                end
            end
            res_ch.ready <= !sink_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // long output stall so the block backs up into its input
    initial
    begin
        while (!hold_req)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input cfg_dat_t value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SYNC_BYTE:   sync_reg    = value[7:0];
            CFG_MAX_PAYLOAD: max_len_reg = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic queue_header(input byte_t sync_val, input len_t len, input bit corrupt);
        byte_t h[HDR_LEN];
        int    k;
        h[0] = sync_val;
        h[1] = byte_t'($urandom_range(255));
        h[2] = len[7:0];
        h[3] = len[15:8];
        h[4] = h[0] ^ h[1] ^ h[2] ^ h[3];
        if (corrupt)
        begin
            k    = $urandom_range(HDR_LEN - 1);
            h[k] = h[k] ^ byte_t'(8'h01 << $urandom_range(7));
        end
        foreach (h[i])
            rx_stream_q.push_back(h[i]);
    endtask

    task automatic queue_frame(input byte_t sync_val, input len_t len);
        queue_header(sync_val, len, 1'b0);
        repeat (len) rx_stream_q.push_back(byte_t'($urandom_range(255)));
    endtask

    function automatic len_t pick_len(input len_t max_len);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 25 && max_len < 16'hFFF0)
            return max_len + len_t'($urandom_range(1, 3));
        if (r < 35 && max_len <= 16'd64)
            return max_len;
        if (max_len == 16'd0)
            return '0;
        return len_t'($urandom_range(1, (max_len < 16'd12) ? int'(max_len) : 12));
    endfunction

    // mostly clean frames, some line noise and damaged headers
    task automatic queue_random_phase(input byte_t sync_val, input len_t max_len, input int n);
        int start;
        int r;
        start = rx_stream_q.size();
        while (rx_stream_q.size() - start < n)
        begin
            r = $urandom_range(99);
            if (r < 80)
                queue_frame(sync_val, pick_len(max_len));
            else if (r < 90)
                repeat ($urandom_range(1, 6)) rx_stream_q.push_back(byte_t'($urandom_range(255)));
            else
                queue_header(sync_val, pick_len(max_len), 1'b1);
        end
    endtask

    // nothing queued, nothing in flight, then room for a byte that gives no result
    task automatic wait_drained();
        while (rx_stream_q.size() != 0 || rx_ch.valid || deframed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        byte_t sync_val;
        len_t  max_val;
        int    p;

        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_SYNC_BYTE;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        sync_reg      = SYNC_RESET;
        max_len_reg   = MAX_PAYLOAD_RESET;
        hunt_fill     = 0;
        streaming     = 1'b0;
        bytes_left    = '0;
        foreach (hunt_win[i])
            hunt_win[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty frame, stray byte before a header, extreme payload bytes
        @(negedge clk);
        queue_frame(SYNC_RESET, 16'd0);
        rx_stream_q.push_back(8'h11);
        queue_header(SYNC_RESET, 16'd2, 1'b0);
        rx_stream_q.push_back(8'h00);
        rx_stream_q.push_back(8'hFF);
        wait_drained();

        // sync 0x00 with max 0: only empty frames get through
        write_reg(CFG_SYNC_BYTE, 16'h0000);
        write_reg(CFG_MAX_PAYLOAD, 16'h0000);
        @(negedge clk);
        queue_frame(8'h00, 16'd0);
        queue_header(8'h00, 16'd1, 1'b0);
        wait_drained();

        // sync 0xff, longest length rejected one below the top; spare indexes do nothing
        write_reg(CFG_SYNC_BYTE, 16'h00FF);
        write_reg(CFG_MAX_PAYLOAD, 16'hFFFE);
        write_reg(CFG_SPARE_2, cfg_dat_t'($urandom_range(16'hFFFF)));
        write_reg(CFG_SPARE_3, 16'hFFFF);
        @(negedge clk);
        queue_header(8'hFF, 16'hFFFF, 1'b0);
        queue_frame(8'hFF, 16'd2);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
            begin
                sync_val = SYNC_RESET;
                max_val  = MAX_PAYLOAD_RESET;
            end
            else
            begin
                sync_val = byte_t'($urandom_range(255));
                max_val  = (p == 3) ? 16'd1 : len_t'($urandom_range(2, 64));
            end
            write_reg(CFG_SYNC_BYTE, cfg_dat_t'(sync_val));
            write_reg(CFG_MAX_PAYLOAD, max_val);
            @(negedge clk);
            queue_random_phase(sync_val, max_val, PHASE_BYTES);
            if (p == 2)
                hold_req <= 1'b1;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("run covered %0d received bytes and %0d output transactions (%0d frames closed, %0d empty)",
                 rx_accepted, results_seen, frames_closed, empty_seen);
        $display("%0d register writes, sync bytes 0x00/0xff/random, max lengths 0 to 65535",
                 cfg_writes);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
